@@ sv/rbs_pkg.sv @@
`timescale 1ns / 1ps

package rbs_pkg;

  // Default number format, signed Q16.16
  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned FRAC_BITS  = 16;

  // Lanes, one per axis
  localparam int unsigned NUM_AXES = 3;

  // Axis codes as they appear on normal_axis
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Per-lane status handed to the merge stage
  typedef struct packed {
    logic par;    // direction is zero on this axis
    logic pmiss;  // parallel axis with the origin outside the slab
  } rbs_flags_t;

endpackage

@@ sv/ray_box_slab_intersection_top.sv @@
`timescale 1ns / 1ps
// Path in order: lane input register, divider stages, lane output register, merge output register.
// Throughput: one transaction per cycle unless the output stalls; the depth
// comes from the restoring dividers, one quotient bit per stage, two per axis lane.
// The whole pipeline advances together and halts while the output waits.
// Reset clears only the valid pipeline; data registers are not reset.

module ray_box_slab_intersection_top import rbs_pkg::*; #(
  parameter int unsigned COORD_W = COORD_BITS,
  parameter int unsigned FRAC_W  = FRAC_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // box_x, box_y, box_z, extent_x, extent_y, extent_z,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [((12*COORD_W+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // hit, entry_x, entry_y, entry_z, normal_axis[1:0], normal_negative
  output logic [((3*COORD_W+4+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned C      = COORD_W;
  localparam int unsigned LAT    = C + 5;
  localparam int unsigned OUT_W  = 3 * C + 4;
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8;

  // Global advance
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic [LAT-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end
  assign m_axis_tvalid = vld_q[LAT-1];

  // Axis lanes
  logic signed [C-1:0] entry [NUM_AXES];
  logic signed [C-1:0] farv  [NUM_AXES];
  rbs_flags_t          flags [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    rbs_lane #(.C(C), .F(FRAC_W)) u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .lo_i    ($signed(s_axis_tdata[a*C +: C])),
      .ext_i   ($signed(s_axis_tdata[(3+a)*C +: C])),
      .org_i   ($signed(s_axis_tdata[(6+a)*C +: C])),
      .dir_i   ($signed(s_axis_tdata[(9+a)*C +: C])),
      .entry_o (entry[a]),
      .far_o   (farv[a]),
      .flags_o (flags[a])
    );
  end

  // Merge
  logic                hit;
  logic signed [C-1:0] res_entry [NUM_AXES];
  logic [1:0]          axis;
  logic                neg;

  rbs_merge #(.C(C)) u_merge (
    .clk_i   (clk_i),
    .en_i    (en),
    .entry_i (entry),
    .far_i   (farv),
    .flags_i (flags),
    .hit_o   (hit),
    .entry_o (res_entry),
    .axis_o  (axis),
    .neg_o   (neg)
  );

  assign m_axis_tdata = OUT_TW'({neg, axis, res_entry[2], res_entry[1], res_entry[0], hit});

endmodule

@@ sv/rbs_div.sv @@
`timescale 1ns / 1ps

// Pipelined restoring divider: (num * 2^F) / den, truncated toward zero,
// saturated to the signed C-bit range. One quotient bit per stage.
module rbs_div import rbs_pkg::*; #(
  parameter int unsigned C = COORD_BITS,
  parameter int unsigned F = FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [C+1:0] num_i,
  input  logic signed [C-1:0] den_i,
  output logic signed [C-1:0] quo_o
);

  localparam int unsigned NW = C + 2 + F;
  localparam int unsigned HW = F + 2;
  localparam int unsigned CW = (HW > C) ? HW : C;

  // Front stage: magnitudes and overflow check
  logic [C+1:0]  mag;
  logic [C-1:0]  dm;
  logic [NW-1:0] nfull;
  logic [HW-1:0] rtop;
  logic          ovf;
  logic          neg;

  always_comb begin
    mag   = num_i[C+1] ? (C+2)'(-num_i) : (C+2)'(num_i);
    dm    = den_i[C-1] ? C'(-den_i) : C'(den_i);
    nfull = {mag, {F{1'b0}}};
    rtop  = nfull[NW-1:C];
    ovf   = (CW'(rtop) >= CW'(dm));
    neg   = num_i[C+1] ^ den_i[C-1];
  end

  logic [C:0]   r_q   [C+1];
  logic [C-1:0] nl_q  [C+1];
  logic [C-1:0] dm_q  [C+1];
  logic [C-1:0] q_q   [C+1];
  logic         neg_q [C+1];
  logic         ovf_q [C+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= (C+1)'(rtop);
      nl_q[0]  <= nfull[C-1:0];
      dm_q[0]  <= dm;
      q_q[0]   <= '0;
      neg_q[0] <= neg;
      ovf_q[0] <= ovf;
    end
  end

  // Iteration stages
  for (genvar k = 0; k < C; k++) begin : g_stage
    logic [C:0] trial;
    logic       ge;
    assign trial = {r_q[k][C-1:0], nl_q[k][C-1]};
    assign ge    = (trial >= {1'b0, dm_q[k]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1]   <= ge ? (trial - {1'b0, dm_q[k]}) : trial;
        nl_q[k+1]  <= {nl_q[k][C-2:0], 1'b0};
        dm_q[k+1]  <= dm_q[k];
        q_q[k+1]   <= {q_q[k][C-2:0], ge};
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  // Saturate and apply sign
  logic [C-1:0] lim;
  logic [C-1:0] qs;
  logic [C-1:0] quo_d;
  logic [C-1:0] quo_q;

  always_comb begin
    lim   = neg_q[C] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
    qs    = (ovf_q[C] || (q_q[C] > lim)) ? lim : q_q[C];
    quo_d = neg_q[C] ? (-qs) : qs;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= quo_d;
    end
  end

  assign quo_o = $signed(quo_q);

endmodule

@@ sv/rbs_lane.sv @@
`timescale 1ns / 1ps

// One axis: slab differences, two dividers, ordering of the pair.
module rbs_lane import rbs_pkg::*; #(
  parameter int unsigned C = COORD_BITS,
  parameter int unsigned F = FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [C-1:0] lo_i,
  input  logic signed [C-1:0] ext_i,
  input  logic signed [C-1:0] org_i,
  input  logic signed [C-1:0] dir_i,
  output logic signed [C-1:0] entry_o,
  output logic signed [C-1:0] far_o,
  output rbs_flags_t          flags_o
);

  localparam int unsigned DIV_LAT = C + 2;

  // Input stage: slab differences
  logic signed [C+1:0] nlo_q;
  logic signed [C+1:0] nhi_q;
  logic signed [C-1:0] den_q;
  logic                par_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nlo_q <= (C+2)'(lo_i) - (C+2)'(org_i);
      nhi_q <= (C+2)'(lo_i) + (C+2)'(ext_i) - (C+2)'(org_i);
      den_q <= dir_i;
      par_q <= (dir_i == '0);
    end
  end

  // Parallel axis with the origin below the corner or beyond the end of the slab
  rbs_flags_t flags_in;
  always_comb begin
    flags_in.par   = par_q;
    flags_in.pmiss = par_q && ((nlo_q > 0) || (nhi_q < 0));
  end

  // Divider pair
  logic signed [C-1:0] qa;
  logic signed [C-1:0] qb;

  rbs_div #(.C(C), .F(F)) u_div_lo (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .num_i  (nlo_q),
    .den_i  (den_q),
    .quo_o  (qa)
  );

  rbs_div #(.C(C), .F(F)) u_div_hi (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .num_i  (nhi_q),
    .den_i  (den_q),
    .quo_o  (qb)
  );

  // Flags travel alongside the dividers
  rbs_flags_t fl_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fl_q[0] <= flags_in;
      for (int i = 1; i < DIV_LAT; i++) begin
        fl_q[i] <= fl_q[i-1];
      end
    end
  end

  // Order the pair; a parallel axis reports entry zero
  logic swap;
  logic signed [C-1:0] entry_d;
  logic signed [C-1:0] far_d;
  logic signed [C-1:0] entry_q;
  logic signed [C-1:0] far_q;
  rbs_flags_t          flags_q;

  always_comb begin
    swap    = (qa > qb);
    entry_d = fl_q[DIV_LAT-1].par ? '0 : (swap ? qb : qa);
    far_d   = swap ? qa : qb;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      entry_q <= entry_d;
      far_q   <= far_d;
      flags_q <= fl_q[DIV_LAT-1];
    end
  end

  assign entry_o = entry_q;
  assign far_o   = far_q;
  assign flags_o = flags_q;

endmodule

@@ sv/rbs_merge.sv @@
`timescale 1ns / 1ps

// Combines the three lanes: running near/far in axis order, hit decision.
module rbs_merge import rbs_pkg::*; #(
  parameter int unsigned C = COORD_BITS
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [C-1:0] entry_i [NUM_AXES],
  input  logic signed [C-1:0] far_i   [NUM_AXES],
  input  rbs_flags_t          flags_i [NUM_AXES],
  output logic                hit_o,
  output logic signed [C-1:0] entry_o [NUM_AXES],
  output logic [1:0]          axis_o,
  output logic                neg_o
);

  logic signed [C-1:0] nearv;
  logic signed [C-1:0] farv;
  logic [1:0]          axis;
  logic                pmiss;
  logic                hit_d;
  logic                neg_d;

  // Near is raised only on a strictly greater entry
  always_comb begin
    nearv = {1'b1, {(C-1){1'b0}}};
    farv  = {1'b0, {(C-1){1'b1}}};
    axis  = AXIS_X;
    pmiss = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      pmiss = pmiss | flags_i[i].pmiss;
      if (!flags_i[i].par) begin
        if (entry_i[i] > nearv) begin
          nearv = entry_i[i];
          axis  = 2'(i);
        end
        if (far_i[i] < farv) begin
          farv = far_i[i];
        end
      end
    end
    hit_d = !pmiss && (nearv <= farv) && (farv >= 0);
    case (axis)
      AXIS_X:  neg_d = !flags_i[0].par;
      AXIS_Y:  neg_d = !flags_i[1].par;
      AXIS_Z:  neg_d = !flags_i[2].par;
      default: neg_d = 1'b0;
    endcase
  end

  // Output register; a miss clears every field
  logic                hit_q;
  logic signed [C-1:0] entry_q [NUM_AXES];
  logic [1:0]          axis_q;
  logic                neg_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q  <= hit_d;
      axis_q <= hit_d ? axis : AXIS_X;
      neg_q  <= hit_d && neg_d;
      for (int i = 0; i < NUM_AXES; i++) begin
        entry_q[i] <= hit_d ? entry_i[i] : '0;
      end
    end
  end

  assign hit_o   = hit_q;
  assign entry_o = entry_q;
  assign axis_o  = axis_q;
  assign neg_o   = neg_q;

endmodule

@@ sv/rbs_checker.sv @@
`timescale 1ns / 1ps

// Port-level checks for the slab test block.
module rbs_checker import rbs_pkg::*; #(
  parameter int unsigned COORD_W = COORD_BITS,
  parameter int unsigned FRAC_W  = FRAC_BITS
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic [((12*COORD_W+7)/8)*8-1:0] s_axis_tdata,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((3*COORD_W+4+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned C = COORD_W;

  // Stalled output transaction holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // A miss carries all-zero result fields
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[3*C+3:1] == '0))
    else $error("miss with nonzero fields");

  // Normal axis is a real axis
  a_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[3*C+2:3*C+1] != 2'd3))
    else $error("bad normal axis");

  // Input side never blocks while the output is empty
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind ray_box_slab_intersection_top rbs_checker #(
  .COORD_W (COORD_W),
  .FRAC_W  (FRAC_W)
) u_rbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
